### rtl/fir_pkg.sv
// Shared constants and types for the integer FIR filter.
`timescale 1ns / 1ps
`default_nettype none

package fir_pkg;

	localparam int MAX_TAPS = 32;
	localparam int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int TAPS_W   = $clog2(MAX_TAPS + 1);
	localparam int DATA_W   = 32;
	localparam int CNT_W    = 6;

	// Item kinds carried on the kind field.
	localparam logic [1:0] KIND_SAMPLE   = 2'd0;
	localparam logic [1:0] KIND_COEFF    = 2'd1;
	localparam logic [1:0] KIND_CLEAR    = 2'd2;
	localparam logic [1:0] KIND_RESERVED = 2'd3;

	typedef logic [DATA_W-1:0] word_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic shift;
		logic rotate;
		logic clear;
	} fir_cell_ctl_t;

endpackage

`default_nettype wire

### rtl/fir_cell.sv
// One filter cell: holds one history sample and one tap coefficient.
`timescale 1ns / 1ps
`default_nettype none

module fir_cell
	import fir_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  fir_cell_ctl_t      ctl,
	input  word_t              hist_prev,
	input  word_t              hist_next,
	input  word_t              coef_next,
	input  wire logic          coef_we,
	input  word_t              coef_wdata,
	output word_t              hist,
	output word_t              coef
);

	word_t hist_q;
	word_t coef_q;

	// A shift moves the history one place older; a rotate moves both words
	// one place toward cell zero, wrapping around the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			coef_q <= '0;
		end else begin
			priority if (ctl.clear) begin
				hist_q <= '0;
			end else if (ctl.shift) begin
				hist_q <= hist_prev;
			end else if (ctl.rotate) begin
				hist_q <= hist_next;
			end else begin
				hist_q <= hist_q;
			end
			priority if (coef_we) begin
				coef_q <= coef_wdata;
			end else if (ctl.rotate) begin
				coef_q <= coef_next;
			end else begin
				coef_q <= coef_q;
			end
		end
	end

	assign hist = hist_q;
	assign coef = coef_q;

endmodule

`default_nettype wire

### rtl/fir_mac.sv
// Multiply-accumulate unit fed from the head of the cell row.
`timescale 1ns / 1ps
`default_nettype none

module fir_mac
	import fir_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic en,
	input  word_t     coef,
	input  word_t     hist,
	output word_t     acc
);

	word_t prod_s1;
	logic  pv_s1;
	word_t acc_q;

	// Only the low word of each product is kept; the sum wraps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			acc_q <= '0;
		end else if (start) begin
			pv_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			pv_s1 <= en;
			if (pv_s1) begin
				acc_q <= acc_q + prod_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * hist;
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

### rtl/fir_filter_int32_unit.sv
// Top level of the integer FIR filter: cell row, MAC and item sequencer.
`timescale 1ns / 1ps
`default_nettype none

// After a sample item is accepted, the sample shifts into the history row,
// then the row of cells rotates once around, one tap per cycle, past a
// single 32x32 multiplier, and the accumulator drains into the output register.
// Coefficient-write and clear items give no result and leave the block ready
// for the next item. Taps beyond tap_count pass the multiplier but are not
// added. The block takes the next item while a finished result still waits on
// the output; a later sample then holds in its last state until the output
// register is free.

module fir_filter_int32_unit
	import fir_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [4:0]         tap_index,
	input  wire logic signed [31:0] sample_or_coeff,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      filtered,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CNT_W-1:0]   cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FLUSH,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [TAP_W-1:0]   step_q;
	logic               out_valid_q;
	word_t              filtered_q;
	logic [CNT_W-1:0]   tap_count_q;
	logic [TAPS_W-1:0]  taps_eff;

	logic               accept;
	logic               mac_start;
	logic               mac_en;
	word_t              acc;
	fir_cell_ctl_t      ctl;
	word_t              hist_w [MAX_TAPS];
	word_t              coef_w [MAX_TAPS];

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= CNT_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			tap_count_q <= cfg_data;
		end
	end

	// Zero taps behave as one; counts above the row length saturate.
	always_comb begin
		priority if (tap_count_q == '0) begin
			taps_eff = TAPS_W'(1);
		end else if (32'(tap_count_q) > MAX_TAPS) begin
			taps_eff = TAPS_W'(MAX_TAPS);
		end else begin
			taps_eff = TAPS_W'(tap_count_q);
		end
	end

	always_comb begin
		ctl.shift  = accept && (kind == KIND_SAMPLE);
		ctl.clear  = accept && (kind == KIND_CLEAR);
		ctl.rotate = (state_q == S_RUN);
	end

	assign mac_start = ctl.shift;
	assign mac_en    = (state_q == S_RUN) && (TAPS_W'(step_q) < taps_eff);

	for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
		word_t prev;
		logic  we;
		if (i == 0) begin : g_head
			assign prev = word_t'(sample_or_coeff);
		end else begin : g_body
			assign prev = hist_w[i-1];
		end
		assign we = accept && (kind == KIND_COEFF) && (32'(tap_index) == i);
		fir_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.hist_prev  (prev),
			.hist_next  (hist_w[(i + 1) % MAX_TAPS]),
			.coef_next  (coef_w[(i + 1) % MAX_TAPS]),
			.coef_we    (we),
			.coef_wdata (word_t'(sample_or_coeff)),
			.hist       (hist_w[i]),
			.coef       (coef_w[i])
		);
	end

	fir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.en     (mac_en),
		.coef   (coef_w[0]),
		.hist   (hist_w[0]),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			filtered_q  <= '0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				filtered_q  <= acc;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (kind == KIND_SAMPLE)) begin
						state_q <= S_RUN;
						step_q  <= '0;
					end
				end
				S_RUN: begin
					if (32'(step_q) == MAX_TAPS - 1) begin
						step_q  <= '0;
						state_q <= S_FLUSH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_FLUSH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = $signed(filtered_q);

	a_sample_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_SAMPLE) |=> (state_q == S_RUN && step_q == '0))
		else $error("sample item did not start a tap pass");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_RUN) |-> (step_q == '0))
		else $error("tap counter left nonzero outside a pass");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result loaded outside the final state");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("finished item overran a waiting result");

endmodule

`default_nettype wire

### tb/sv/tb_fir_filter_int32_unit.sv
// Self-checking testbench for the integer FIR filter unit.
`timescale 1ns / 1ps

module tb_fir_filter_int32_unit
	import fir_pkg::*;
();

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = MAX_TAPS + 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         kind = KIND_SAMPLE;
	logic [4:0]         tap_index = '0;
	logic signed [31:0] sample_or_coeff = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] filtered;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data = '0;

	// Filter state as the testbench sees it.
	word_t            hist_words[MAX_TAPS];
	word_t            coeff_words[MAX_TAPS];
	logic [TAP_W-1:0] next_slot;
	logic [CNT_W-1:0] tap_setting;

	word_t pending_outputs[$];

	int errors = 0;
	int cycles = 0;
	int n_samples = 0;
	int n_coeffs = 0;
	int n_clears = 0;
	int n_ignored = 0;
	int n_checked = 0;
	int n_settings = 0;

	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int rx_gap = 0;
	int hold_request = 0;
	bit rx_holding = 1'b0;

	fir_filter_int32_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.tap_index       (tap_index),
		.sample_or_coeff (sample_or_coeff),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.filtered        (filtered),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d outputs outstanding",
				$time, cycles, pending_outputs.size());
			$display("fir_filter_int32_unit verification failed");
			$finish;
		end
	end

	// Applies one accepted item to the filter state and queues any output it produces.
	task automatic filter_step(input logic [1:0] k, input logic [4:0] idx, input word_t w);
		int               taps;
		word_t            acc;
		word_t            prod;
		logic [TAP_W-1:0] slot;
		case (k)
			KIND_SAMPLE: begin
				taps = (tap_setting == 0) ? 1 :
					(tap_setting > MAX_TAPS) ? MAX_TAPS : int'(tap_setting);
				hist_words[next_slot] = w;
				acc = '0;
				for (int j = 0; j < taps; j++) begin
					slot = next_slot - TAP_W'(j);
					prod = coeff_words[j] * hist_words[slot];
					acc = acc + prod;
				end
				next_slot = next_slot + 1'b1;
				pending_outputs.push_back(acc);
				n_samples++;
			end
			KIND_COEFF: begin
				coeff_words[idx] = w;
				n_coeffs++;
			end
			KIND_CLEAR: begin
				foreach (hist_words[i]) hist_words[i] = '0;
				next_slot = '0;
				n_clears++;
			end
			default: n_ignored++;
		endcase
	endtask

	// Offers one item, after a random gap while tx_idle_en is set, and returns at the edge where it is taken.
	task automatic send_item(input logic [1:0] k, input logic [4:0] idx, input word_t w);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 15) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		tap_index <= idx;
		sample_or_coeff <= w;
		do @(posedge clk); while (!in_ready);
		filter_step(k, idx, w);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Waits until every queued output has come back and the pipeline has settled.
	task automatic wait_drained();
		drop_valid();
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_tap_count(input logic [CNT_W-1:0] n);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		tap_setting = n;
		n_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4: return word_t'($urandom_range(0, 15)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	// Receiver: while rx_idle_en is set, each taken output is followed by a random wait; a long hold keeps out_ready low.
	always @(negedge clk) begin
		if (!arst_n || rx_holding) begin
			out_ready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Long receiver stall, counted here so the sender keeps running meanwhile.
	initial begin : rx_hold
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				rx_holding = 1'b1;
				repeat (hold_request) @(posedge clk);
				rx_holding = 1'b0;
				hold_request = 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected output, expected none, actual %h", $time, filtered);
				errors++;
			end else begin
				if (filtered !== pending_outputs[0]) begin
					$display("%0t: filtered mismatch, expected %h, actual %h",
						$time, pending_outputs[0], filtered);
					errors++;
				end
				void'(pending_outputs.pop_front());
				n_checked++;
			end
			rx_gap = rx_idle_en ? $urandom_range(0, 15) : 0;
		end
	end

	// With all coefficients zero after reset, every output is zero.
	task automatic test_reset_defaults();
		send_item(KIND_SAMPLE, 5'd0, 32'h7FFF_FFFF);
		send_item(KIND_SAMPLE, 5'd31, 32'h8000_0000);
	endtask

	task automatic test_field_extremes();
		send_item(KIND_COEFF, 5'd0, 32'h0000_0001);
		send_item(KIND_COEFF, 5'd1, 32'hFFFF_FFFF);
		send_item(KIND_COEFF, 5'd30, 32'h7FFF_FFFF);
		send_item(KIND_COEFF, 5'd31, 32'h8000_0000);
		send_item(KIND_SAMPLE, 5'd0, 32'h8000_0000);
		send_item(KIND_SAMPLE, 5'd0, 32'h7FFF_FFFF);
		send_item(KIND_SAMPLE, 5'd0, 32'hFFFF_FFFF);
		send_item(KIND_SAMPLE, 5'd0, 32'h0000_0000);
		// The reserved kind must leave the coefficients alone.
		send_item(KIND_RESERVED, 5'd0, 32'h1234_5678);
		send_item(KIND_SAMPLE, 5'd17, 32'h0000_0003);
	endtask

	task automatic test_clear_history();
		send_item(KIND_CLEAR, 5'd0, 32'hDEAD_BEEF);
		send_item(KIND_SAMPLE, 5'd0, 32'h0000_0002);
	endtask

	// Zero acts as one tap and anything above the maximum saturates.
	task automatic test_tap_limits();
		logic [CNT_W-1:0] settings[5] = '{6'd0, 6'd1, 6'd33, 6'd63, 6'd32};
		foreach (settings[i]) begin
			set_tap_count(settings[i]);
			send_item(KIND_SAMPLE, 5'd0, pick_word());
		end
	endtask

	// The receiver stops for a long stretch while samples keep arriving back to back.
	task automatic test_back_pressure();
		wait_drained();
		tx_idle_en = 1'b0;
		hold_request = 400;
		for (int i = 0; i < 12; i++) begin
			send_item(KIND_SAMPLE, 5'($urandom), pick_word());
		end
		wait_drained();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_random_traffic();
		int               phase_items;
		int               r;
		logic [CNT_W-1:0] n;
		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 0) n = 6'd32;
			else if (phase == 1) n = 6'd1;
			else if (phase == 5) n = 6'($urandom_range(0, 63));
			else n = 6'($urandom_range(1, 32));
			set_tap_count(n);
			tx_idle_en = (phase % 4) < 2;
			rx_idle_en = (phase % 4) == 0 || (phase % 4) == 2;
			phase_items = 0;
			while (phase_items < 65) begin
				r = $urandom_range(0, 99);
				if (r < 62) begin
					send_item(KIND_SAMPLE, 5'($urandom), pick_word());
					phase_items++;
				end else if (r < 90) begin
					send_item(KIND_COEFF, 5'($urandom), pick_word());
					phase_items++;
				end else if (r < 94) begin
					send_item(KIND_CLEAR, 5'($urandom), $urandom);
					phase_items++;
				end else begin
					send_item(KIND_RESERVED, 5'($urandom), $urandom);
				end
			end
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		foreach (hist_words[i]) hist_words[i] = '0;
		foreach (coeff_words[i]) coeff_words[i] = '0;
		next_slot = '0;
		tap_setting = 6'd32;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_field_extremes();
		test_clear_history();
		test_tap_limits();
		test_back_pressure();
		test_random_traffic();

		wait_drained();

		$display("Sent %0d samples, %0d coefficient writes, %0d clears, %0d reserved items.",
			n_samples, n_coeffs, n_clears, n_ignored);
		$display("Checked %0d outputs over %0d tap settings, %0d mismatches.",
			n_checked, n_settings, errors);
		if (errors == 0) begin
			$display("fir_filter_int32_unit verification clean");
		end else begin
			$display("fir_filter_int32_unit verification failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/fir_pkg.sv
rtl/fir_cell.sv
rtl/fir_mac.sv
rtl/fir_filter_int32_unit.sv
tb/sv/tb_fir_filter_int32_unit.sv
